// File: rtl/lcdns_pkg.sv
`timescale 1ns / 1ps

package lcdns_pkg;

    // request codes
    localparam logic [2:0] CMD_INIT    = 3'd0;
    localparam logic [2:0] CMD_COMMAND = 3'd1;
    localparam logic [2:0] CMD_DATA    = 3'd2;
    localparam logic [2:0] CMD_CURSOR  = 3'd3;
    localparam logic [2:0] CMD_PRINT   = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_STROBE_HIGH = 3'd0;
    localparam logic [2:0] CFG_SETTLE      = 3'd1;
    localparam logic [2:0] CFG_LONG_CMD    = 3'd2;
    localparam logic [2:0] CFG_POWER_UP    = 3'd3;
    localparam logic [2:0] CFG_FIRST_GAP   = 3'd4;
    localparam logic [2:0] CFG_INIT_GAP    = 3'd5;

    // register reset values
    localparam logic [7:0]  RST_STROBE_HIGH = 8'd1;
    localparam logic [9:0]  RST_SETTLE      = 10'd50;
    localparam logic [15:0] RST_LONG_CMD    = 16'd2000;
    localparam logic [15:0] RST_POWER_UP    = 16'd20000;
    localparam logic [15:0] RST_FIRST_GAP   = 16'd5000;
    localparam logic [9:0]  RST_INIT_GAP    = 10'd150;

    // display command bytes
    localparam logic [7:0] DISP_CLEAR      = 8'h01;
    localparam logic [7:0] RETURN_HOME     = 8'h02;
    localparam logic [7:0] LCD_FUNC_4BIT   = 8'h28;
    localparam logic [7:0] LCD_DISP_OFF    = 8'h08;
    localparam logic [7:0] LCD_ENTRY_MODE  = 8'h06;
    localparam logic [7:0] LCD_DISP_ON     = 8'h0C;
    localparam logic [7:0] LCD_SET_DDRAM   = 8'h80;
    localparam logic [7:0] LCD_ROW2_OFFSET = 8'h40;
    localparam logic [3:0] LCD_WAKE_NIB    = 4'h3;
    localparam logic [3:0] LCD_4BIT_NIB    = 4'h2;
    localparam logic [7:0] ASCII_ZERO      = 8'h30;

    // divide by ten: (v * 0xCCCD) >> 19 is exact for 16-bit v
    localparam logic [15:0] DIV10_MULT  = 16'hCCCD;
    localparam int          DIV10_SHIFT = 19;

    localparam int INIT_JOBS       = 9;
    localparam int QUEUE_DEPTH_DEF = 4;

    // one queued job: an init nibble or a whole byte
    typedef struct packed {
        logic       nib_only;
        logic       first;
        logic       rs;
        logic [7:0] data;
        logic       last;
    } job_t;

    typedef struct packed {
        logic [7:0]  strobe_high;
        logic [9:0]  settle;
        logic [15:0] long_cmd;
        logic [15:0] power_up;
        logic [15:0] first_gap;
        logic [9:0]  init_gap;
    } cfg_t;

    // power-up init run, one job per entry
    function automatic job_t init_job(input logic [3:0] idx);
        job_t j;
        j = '{nib_only: 1'b0, first: 1'b0, rs: 1'b0, data: 8'h00, last: 1'b0};
        unique case (idx)
            4'd0: begin
                j.nib_only = 1'b1;
                j.first    = 1'b1;
                j.data     = {4'h0, LCD_WAKE_NIB};
            end
            4'd1, 4'd2: begin
                j.nib_only = 1'b1;
                j.data     = {4'h0, LCD_WAKE_NIB};
            end
            4'd3: begin
                j.nib_only = 1'b1;
                j.data     = {4'h0, LCD_4BIT_NIB};
            end
            4'd4: j.data = LCD_FUNC_4BIT;
            4'd5: j.data = LCD_DISP_OFF;
            4'd6: j.data = DISP_CLEAR;
            4'd7: j.data = LCD_ENTRY_MODE;
            4'd8: begin
                j.data = LCD_DISP_ON;
                j.last = 1'b1;
            end
            default: j.data = 8'h00;
        endcase
        return j;
    endfunction

endpackage

// File: rtl/lcdns_front.sv
`timescale 1ns / 1ps

module lcdns_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          s_cmd,
    input  logic [15:0]         s_value,
    input  logic                s_row,
    input  logic [3:0]          s_col,
    output logic                push_valid,
    input  logic                push_ready,
    output lcdns_pkg::job_t     push_job
);
    import lcdns_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_INIT   = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_DIGITS = 3'd3;
    localparam logic [2:0] ST_ONE    = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [3:0]  idx_reg, idx_next;
    logic [2:0]  dcnt_reg, dcnt_next;
    logic [15:0] val_reg, val_next;
    job_t        one_job_reg, one_job_next;
    logic [3:0]  digits_reg [5];

    logic [31:0] prod;
    logic [15:0] quot;
    logic [15:0] rem;
    logic        accept;
    logic        push_done;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign push_done = push_valid && push_ready;

    // one decimal digit per cycle, least significant first
    assign prod = {16'd0, val_reg} * {16'd0, DIV10_MULT};
    assign quot = prod[31:DIV10_SHIFT] == '0 ? 16'd0 : 16'(prod >> DIV10_SHIFT);
    assign rem  = val_reg - ((quot << 3) + (quot << 1));

    // job presented to the queue
    always_comb begin
        push_valid = 1'b0;
        push_job   = one_job_reg;
        unique case (state_reg)
            ST_INIT: begin
                push_valid = 1'b1;
                push_job   = init_job(idx_reg);
            end
            ST_DIGITS: begin
                push_valid        = 1'b1;
                push_job.nib_only = 1'b0;
                push_job.first    = 1'b0;
                push_job.rs       = 1'b1;
                push_job.data     = ASCII_ZERO | {4'h0, digits_reg[idx_reg[2:0]]};
                push_job.last     = (idx_reg == 4'd0);
            end
            ST_ONE: push_valid = 1'b1;
            default: push_valid = 1'b0;
        endcase
    end

    // request decode and sequencing
    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        dcnt_next    = dcnt_reg;
        val_next     = val_reg;
        one_job_next = one_job_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    one_job_next.nib_only = 1'b0;
                    one_job_next.first    = 1'b0;
                    one_job_next.last     = 1'b1;
                    one_job_next.rs       = 1'b0;
                    one_job_next.data     = s_value[7:0];
                    case (s_cmd)
                        CMD_INIT: begin
                            idx_next   = 4'd0;
                            state_next = ST_INIT;
                        end
                        CMD_COMMAND: state_next = ST_ONE;
                        CMD_DATA: begin
                            one_job_next.rs = 1'b1;
                            state_next      = ST_ONE;
                        end
                        CMD_CURSOR: begin
                            one_job_next.data = LCD_SET_DDRAM
                                | (s_row ? LCD_ROW2_OFFSET : 8'h00) | {4'h0, s_col};
                            state_next = ST_ONE;
                        end
                        CMD_PRINT: begin
                            val_next   = s_value;
                            dcnt_next  = 3'd0;
                            state_next = ST_DIV;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_INIT: begin
                if (push_done) begin
                    if (idx_reg == 4'(INIT_JOBS - 1)) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next = idx_reg + 4'd1;
                    end
                end
            end
            ST_DIV: begin
                val_next  = quot;
                dcnt_next = dcnt_reg + 3'd1;
                if (quot == 16'd0) begin
                    idx_next   = {1'b0, dcnt_reg};
                    state_next = ST_DIGITS;
                end
            end
            ST_DIGITS: begin
                if (push_done) begin
                    if (idx_reg == 4'd0) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next = idx_reg - 4'd1;
                    end
                end
            end
            ST_ONE: begin
                if (push_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= 4'd0;
            dcnt_reg  <= 3'd0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            dcnt_reg  <= dcnt_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        val_reg     <= val_next;
        one_job_reg <= one_job_next;
        if (state_reg == ST_DIV) begin
            digits_reg[dcnt_reg] <= rem[3:0];
        end
    end

    a_dcnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        dcnt_reg <= 3'd5)
        else $error("digit count beyond five");

    a_digit_index: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIGITS |-> idx_reg < {1'b0, dcnt_reg})
        else $error("digit index past stored digits");

endmodule

// File: rtl/lcdns_queue.sv
`timescale 1ns / 1ps

module lcdns_queue #(
    parameter int DEPTH = lcdns_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    output logic                push_ready,
    input  lcdns_pkg::job_t     push_job,
    output logic                pop_valid,
    input  logic                pop_ready,
    output lcdns_pkg::job_t     pop_job
);
    import lcdns_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // job storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

// File: rtl/lcdns_back.sv
`timescale 1ns / 1ps

module lcdns_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  lcdns_pkg::cfg_t     cfg,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  lcdns_pkg::job_t     pop_job,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_reg_select,
    output logic [3:0]          m_nibble,
    output logic [15:0]         m_lead_us,
    output logic [7:0]          m_pulse_us,
    output logic [16:0]         m_settle_us,
    output logic                m_last
);
    import lcdns_pkg::*;

    logic        busy_reg;
    logic        phase_reg;
    job_t        job_reg;
    logic        m_valid_reg;
    logic        rs_reg;
    logic [3:0]  nib_reg;
    logic [15:0] lead_reg;
    logic [7:0]  pulse_reg;
    logic [16:0] settle_reg;
    logic        last_reg;

    logic        out_free;
    logic        emit;
    logic        done;
    logic        long_cmd;
    logic [15:0] extra;
    logic [3:0]  nib;

    assign pop_ready = !busy_reg;
    assign out_free  = !m_valid_reg || m_ready;
    assign emit      = busy_reg && out_free;
    assign done      = job_reg.nib_only || phase_reg;

    // clear and home in the instruction register add the long wait
    assign long_cmd = !job_reg.rs && (job_reg.data == DISP_CLEAR || job_reg.data == RETURN_HOME);

    // fields of the current transfer
    always_comb begin
        if (job_reg.nib_only) begin
            nib   = job_reg.data[3:0];
            extra = job_reg.first ? cfg.first_gap : {6'd0, cfg.init_gap};
        end else if (phase_reg) begin
            nib   = job_reg.data[3:0];
            extra = long_cmd ? cfg.long_cmd : 16'd0;
        end else begin
            nib   = job_reg.data[7:4];
            extra = 16'd0;
        end
    end

    // job pickup and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            phase_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (!busy_reg && pop_valid) begin
                busy_reg  <= 1'b1;
                phase_reg <= 1'b0;
            end else if (emit) begin
                if (done) begin
                    busy_reg <= 1'b0;
                end else begin
                    phase_reg <= 1'b1;
                end
            end
        end
    end

    // job and output payload
    always_ff @(posedge aclk) begin
        if (!busy_reg && pop_valid) begin
            job_reg <= pop_job;
        end
        if (emit) begin
            rs_reg     <= job_reg.rs;
            nib_reg    <= nib;
            lead_reg   <= (job_reg.nib_only && job_reg.first) ? cfg.power_up : 16'd0;
            pulse_reg  <= (cfg.strobe_high == 8'd0) ? 8'd1 : cfg.strobe_high;
            settle_reg <= {7'd0, cfg.settle} + {1'b0, extra};
            last_reg   <= job_reg.last && done;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_reg_select = rs_reg;
    assign m_nibble     = nib_reg;
    assign m_lead_us    = lead_reg;
    assign m_pulse_us   = pulse_reg;
    assign m_settle_us  = settle_reg;
    assign m_last       = last_reg;

    a_nib_one_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && job_reg.nib_only |-> !phase_reg)
        else $error("init nibble entered second phase");

    a_pulse_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> pulse_reg != 8'd0)
        else $error("zero enable time on a transfer");

endmodule

// File: rtl/char_lcd_nibble_sequencer.sv
`timescale 1ns / 1ps

// Character LCD sequencer for a 4-bit display bus.
// Input channel (s_*): one request per transfer: init, command byte, data byte,
// set cursor or print an unsigned decimal number.
// Output channel (m_*): one item per enable strobe with register select,
// nibble, lead wait, enable high time, settle time and a last flag that marks
// the final strobe of each request.
// Configuration channel (cfg_*): always ready; register index and data, to be
// written only while no request is in flight. Unknown indexes are dropped.
// Path: a byte request passes the front end state, a queue slot, the job register
// and the output register; printing first divides out all its decimal digits.
// Output stage: it picks up each job from the queue and then emits its strobes,
// one strobe for an init nibble and two for a byte, so init makes fourteen
// strobes. It takes the next job only after the last strobe of the current one.
// A request with an undecoded code is taken and dropped without any job.
// The front end takes a new request once every job of the previous one sits
// in the job queue, so it runs ahead of the output by the queue depth.
// When the receiver stalls, the output register holds its item, the queue
// fills and the input channel stops after that.
// Reset clears the queue and both state machines and loads the timing
// registers with their power-on values; no clearing pass is needed.

module char_lcd_nibble_sequencer #(
    parameter int QUEUE_DEPTH = lcdns_pkg::QUEUE_DEPTH_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [2:0]   s_cmd,
    input  logic [15:0]  s_value,
    input  logic         s_row,
    input  logic [3:0]   s_col,
    output logic         m_valid,
    input  logic         m_ready,
    output logic         m_reg_select,
    output logic [3:0]   m_nibble,
    output logic [15:0]  m_lead_us,
    output logic [7:0]   m_pulse_us,
    output logic [16:0]  m_settle_us,
    output logic         m_last,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data
);
    import lcdns_pkg::*;

    cfg_t cfg_reg;
    logic push_valid, push_ready;
    job_t push_job;
    logic pop_valid, pop_ready;
    job_t pop_job;

    assign cfg_ready = 1'b1;

    // timing registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.strobe_high <= RST_STROBE_HIGH;
            cfg_reg.settle      <= RST_SETTLE;
            cfg_reg.long_cmd    <= RST_LONG_CMD;
            cfg_reg.power_up    <= RST_POWER_UP;
            cfg_reg.first_gap   <= RST_FIRST_GAP;
            cfg_reg.init_gap    <= RST_INIT_GAP;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_STROBE_HIGH: cfg_reg.strobe_high <= cfg_data[7:0];
                CFG_SETTLE:      cfg_reg.settle      <= cfg_data[9:0];
                CFG_LONG_CMD:    cfg_reg.long_cmd    <= cfg_data;
                CFG_POWER_UP:    cfg_reg.power_up    <= cfg_data;
                CFG_FIRST_GAP:   cfg_reg.first_gap   <= cfg_data;
                CFG_INIT_GAP:    cfg_reg.init_gap    <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // request decode and job generation
    lcdns_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_cmd      (s_cmd),
        .s_value    (s_value),
        .s_row      (s_row),
        .s_col      (s_col),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    // job queue between front and back
    lcdns_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    // strobe generation
    lcdns_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_job      (pop_job),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_reg_select (m_reg_select),
        .m_nibble     (m_nibble),
        .m_lead_us    (m_lead_us),
        .m_pulse_us   (m_pulse_us),
        .m_settle_us  (m_settle_us),
        .m_last       (m_last)
    );

endmodule
